// ----- design/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tcw_pkg
// Shared types and constants of the text console writer: operation codes,
// register indexes, cell constants and the window and result structures.
// ============================================================================
package tcw_pkg;

  // Default screen geometry.
  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;

  // Fixed field widths of the channels.
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int INDEX_W  = 11;
  localparam int POS_W    = 11;
  localparam int CELL_W   = CHAR_W + COLOR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd3;

  // Character and cell constants.
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [COLOR_W-1:0] BLANK_COLOR = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_COLOR, CHAR_SPACE};

  // Text window settings.
  typedef struct packed {
    logic [6:0] left;
    logic [4:0] top;
    logic [6:0] width;
    logic [4:0] height;
  } tcw_win_t;

  // One result beat.
  typedef struct packed {
    logic [POS_W-1:0]   cursor_pos;
    logic               scrolled;
    logic [CHAR_W-1:0]  cell_char;
    logic [COLOR_W-1:0] cell_color;
  } tcw_result_t;

endpackage

// ----- design/tcw_item_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tcw_item_if
// Input item channel: valid/ready handshake with the item fields.
// ============================================================================
interface tcw_item_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::OP_W-1:0]       op;
  logic [tcw_pkg::CHAR_W-1:0]     char_code;
  logic [tcw_pkg::COLOR_W-1:0]    color;
  logic [tcw_pkg::INDEX_W-1:0]    cell_index;

  modport source (output valid, op, char_code, color, cell_index, input ready);
  modport sink   (input valid, op, char_code, color, cell_index, output ready);
endinterface

// ----- design/tcw_result_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tcw_result_if
// Result channel: valid/ready handshake with the result fields.
// ============================================================================
interface tcw_result_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::POS_W-1:0]      cursor_pos;
  logic                           scrolled;
  logic [tcw_pkg::CHAR_W-1:0]     cell_char;
  logic [tcw_pkg::COLOR_W-1:0]    cell_color;

  modport source (output valid, cursor_pos, scrolled, cell_char, cell_color, input ready);
  modport sink   (input valid, cursor_pos, scrolled, cell_char, cell_color, output ready);
endinterface

// ----- design/tcw_cfg_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tcw_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface tcw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tcw_pkg::CFG_IDX_W-1:0]   index;
  logic [tcw_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/tcw_cell_mem.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tcw_cell_mem
// Character cell store: one write port and one read port, read data
// registered and held while no read is issued.
// ============================================================================
module tcw_cell_mem #(
  parameter int DEPTH = tcw_pkg::DEF_SCREEN_COLUMNS * tcw_pkg::DEF_SCREEN_ROWS
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [$clog2(DEPTH)-1:0]    waddr,
  input  logic [tcw_pkg::CELL_W-1:0]  wdata,
  input  logic                        re,
  input  logic [$clog2(DEPTH)-1:0]    raddr,
  output logic [tcw_pkg::CELL_W-1:0]  rdata
);

  logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/tcw_seq.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tcw_seq
// Console sequencer: keeps the cursor, runs the clearing pass after reset,
// and walks the window for scroll and clear, reading and writing the cell
// store through a registered write stage. A copy read that hits the cell
// still waiting in the write stage takes its data from that stage.
// ============================================================================
module tcw_seq #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS,
  localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input item
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [tcw_pkg::OP_W-1:0]      item_op,
  input  logic [tcw_pkg::CHAR_W-1:0]    item_char,
  input  logic [tcw_pkg::COLOR_W-1:0]   item_color,
  input  logic [tcw_pkg::INDEX_W-1:0]   item_index,
  // Window settings
  input  tcw_pkg::tcw_win_t             win,
  // Result towards the output register
  output logic                          res_valid,
  input  logic                          res_ready,
  output tcw_pkg::tcw_result_t          res,
  // Cell store ports
  output logic                          mem_we,
  output logic [ADDR_W-1:0]             mem_waddr,
  output logic [tcw_pkg::CELL_W-1:0]    mem_wdata,
  output logic                          mem_re,
  output logic [ADDR_W-1:0]             mem_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]    mem_rdata
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  function automatic logic on_screen(input logic [7:0] x, input logic [5:0] y);
    return (32'(x) < SCREEN_COLUMNS) && (32'(y) < SCREEN_ROWS);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] x,
                                                  input logic [5:0] y);
    return ADDR_W'(ADDR_W'(y) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(x));
  endfunction

  // Control state
  logic [2:0]              state;
  logic [ADDR_W-1:0]       init_addr;
  logic [6:0]              col;
  logic [4:0]              row;

  // Latched item
  logic [tcw_pkg::OP_W-1:0]    op_q;
  logic [tcw_pkg::CHAR_W-1:0]  char_q;
  logic [tcw_pkg::COLOR_W-1:0] color_q;
  logic [tcw_pkg::INDEX_W-1:0] idx_q;
  logic                        scrolled_q;
  logic                        rd_ok_q;

  // Window walk
  logic       mode_copy;
  logic [7:0] sx;
  logic [5:0] sy;
  logic [5:0] row_end;

  // Write stage
  logic                       wr_valid;
  logic [ADDR_W-1:0]          wr_addr;
  logic                       wr_from_mem;
  logic                       wr_src_ok;
  logic [tcw_pkg::CELL_W-1:0] wr_const;
  logic                       wr_fwd;
  logic [tcw_pkg::CELL_W-1:0] wr_fwd_data;

  // Write requests issued this cycle
  logic                       req_valid;
  logic [ADDR_W-1:0]          req_addr;
  logic                       req_from_mem;
  logic                       req_src_ok;
  logic [tcw_pkg::CELL_W-1:0] req_const;

  // Derived window figures
  logic [4:0] eff_h;
  logic [5:0] last_row;
  logic [7:0] x_end;
  logic [7:0] cur_x;
  logic [5:0] cur_y;
  logic [5:0] src_y;
  logic       walk_row_done;
  logic       walk_col_done;
  logic       idx_ok;

  // Put cursor update
  logic [6:0] col_inc;
  logic [6:0] col_n;
  logic [4:0] row_n;
  logic       need_scroll;
  logic [15:0] pos_full;

  assign eff_h    = (win.height < 5'd2) ? 5'd2 : win.height;
  assign last_row = {1'b0, win.top} + {1'b0, eff_h} - 6'd2;
  assign x_end    = {1'b0, win.left} + {1'b0, win.width};
  assign cur_x    = {1'b0, win.left} + {1'b0, col};
  assign cur_y    = {1'b0, win.top} + {1'b0, row};
  assign src_y    = sy + 6'd1;
  assign walk_row_done = (sy >= row_end);
  assign walk_col_done = (sx >= x_end);
  assign idx_ok   = 32'(idx_q) < CELLS;

  // Cursor movement of a put, before any scroll.
  always_comb begin
    col_inc = col + 7'd1;
    if (char_q == tcw_pkg::CHAR_NEWLINE) begin
      col_n = 7'd0;
      row_n = row + 5'd1;
    end else if (col_inc >= win.width) begin
      col_n = 7'd0;
      row_n = row + 5'd1;
    end else begin
      col_n = col_inc;
      row_n = row;
    end
    need_scroll = (row_n >= (eff_h - 5'd1));
  end

  // Memory reads and write requests for the current state.
  always_comb begin
    req_valid    = 1'b0;
    req_addr     = '0;
    req_from_mem = 1'b0;
    req_src_ok   = 1'b0;
    req_const    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    unique case (state)
      S_INIT: begin
        req_valid = 1'b1;
        req_addr  = init_addr;
      end
      S_EXEC: begin
        if (op_q == tcw_pkg::OP_PUT && char_q != tcw_pkg::CHAR_NEWLINE) begin
          req_valid = on_screen(cur_x, cur_y);
          req_addr  = cell_addr(cur_x, cur_y);
          req_const = {color_q, char_q};
        end else if (op_q == tcw_pkg::OP_READ) begin
          mem_re    = idx_ok;
          mem_raddr = ADDR_W'(idx_q);
        end
      end
      S_SCAN: begin
        if (!walk_row_done && !walk_col_done) begin
          req_valid = on_screen(sx, sy);
          req_addr  = cell_addr(sx, sy);
          if (mode_copy) begin
            req_from_mem = 1'b1;
            req_src_ok   = on_screen(sx, src_y);
            mem_re       = on_screen(sx, src_y);
            mem_raddr    = cell_addr(sx, src_y);
          end else begin
            req_const = tcw_pkg::BLANK_CELL;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_addr <= '0;
      col       <= 7'd0;
      row       <= 5'd0;
    end else begin
      unique case (state)
        S_INIT: begin
          if (init_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            init_addr <= init_addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            op_q       <= item_op;
            char_q     <= item_char;
            color_q    <= item_color;
            idx_q      <= item_index;
            scrolled_q <= 1'b0;
            rd_ok_q    <= 1'b0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (op_q)
            tcw_pkg::OP_PUT: begin
              col        <= col_n;
              row        <= need_scroll ? row_n - 5'd1 : row_n;
              scrolled_q <= need_scroll;
              mode_copy  <= 1'b1;
              sx         <= {1'b0, win.left};
              sy         <= {1'b0, win.top};
              row_end    <= last_row;
              state      <= need_scroll ? S_SCAN : S_DONE;
            end
            tcw_pkg::OP_CLEAR: begin
              col       <= 7'd0;
              row       <= 5'd0;
              mode_copy <= 1'b0;
              sx        <= {1'b0, win.left};
              sy        <= {1'b0, win.top};
              row_end   <= last_row + 6'd1;
              state     <= S_SCAN;
            end
            tcw_pkg::OP_READ: begin
              rd_ok_q <= idx_ok;
              state   <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_SCAN: begin
          priority if (walk_row_done) begin
            if (mode_copy) begin
              // Copy finished: blank the freed last row.
              mode_copy <= 1'b0;
              sx        <= {1'b0, win.left};
              sy        <= last_row;
              row_end   <= last_row + 6'd1;
            end else begin
              state <= S_DONE;
            end
          end else if (walk_col_done) begin
            sx <= {1'b0, win.left};
            sy <= sy + 6'd1;
          end else begin
            sx <= sx + 8'd1;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  // Write stage: the request lands in the next cycle, with read data to hand.
  // A copy read of the cell being written in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else begin
      wr_valid <= req_valid;
    end
    wr_addr     <= req_addr;
    wr_from_mem <= req_from_mem;
    wr_src_ok   <= req_src_ok;
    wr_const    <= req_const;
    wr_fwd      <= req_from_mem && req_src_ok && wr_valid && (wr_addr == mem_raddr);
    wr_fwd_data <= mem_wdata;
  end

  assign mem_we    = wr_valid;
  assign mem_waddr = wr_addr;
  assign mem_wdata = wr_from_mem ?
                     (wr_src_ok ? (wr_fwd ? wr_fwd_data : mem_rdata) : '0) : wr_const;

  // Result of the finished item.
  assign pos_full = 16'(cur_y) * 16'(SCREEN_COLUMNS) + 16'(cur_x);

  assign item_ready     = (state == S_IDLE);
  assign res_valid      = (state == S_DONE);
  assign res.cursor_pos = pos_full[tcw_pkg::POS_W-1:0];
  assign res.scrolled   = scrolled_q;
  assign res.cell_char  = rd_ok_q ? mem_rdata[tcw_pkg::CHAR_W-1:0] : '0;
  assign res.cell_color = rd_ok_q ? mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;

endmodule

// ----- design/text_console_writer_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// text_console_writer_top
// Text console engine over a character cell store with a scrolling window.
// ============================================================================
// Usage:
//   items   : input beats (op, char_code, color, cell_index). Op put places a
//             character at the cursor or takes a newline, op clear blanks the
//             window and homes the cursor, op read returns one cell.
//   results : one beat per item with the cursor position, the scroll flag
//             and, for a read, the cell's character and attribute.
//   cfg     : register writes (window left, top, width, height), accepted
//             in every cycle; write them only while no item is in flight.
// Item flow:
//   A put that scrolls walks the window once through the cell store port,
//   copying each row up and blanking the freed last row; a clear walks
//   the window once. One item is worked on at a time.
// Reset:
//   Reset homes the cursor, loads the default window and starts a clearing
//   pass over all SCREEN_COLUMNS*SCREEN_ROWS cells, during which no item
//   is accepted.
// Back-pressure:
//   A result waits in the output register while the receiver stalls; the
//   next item is still accepted and held until that register frees up.
// ============================================================================
module text_console_writer_top #(
  parameter int SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::DEF_SCREEN_ROWS
) (
  input  logic         clk,
  input  logic         rst,
  tcw_item_if.sink     items,
  tcw_result_if.source results,
  tcw_cfg_if.sink      cfg
);

  localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  tcw_pkg::tcw_win_t    win;
  tcw_pkg::tcw_result_t res;
  tcw_pkg::tcw_result_t out_res;
  logic                 res_valid;
  logic                 res_ready;
  logic                 out_valid;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  // Window registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.left   <= 7'd0;
      win.top    <= 5'd0;
      win.width  <= 7'(tcw_pkg::DEF_SCREEN_COLUMNS);
      win.height <= 5'(tcw_pkg::DEF_SCREEN_ROWS);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tcw_pkg::REG_WINDOW_LEFT:   win.left   <= cfg.data;
        tcw_pkg::REG_WINDOW_TOP:    win.top    <= cfg.data[4:0];
        tcw_pkg::REG_WINDOW_WIDTH:  win.width  <= cfg.data;
        tcw_pkg::REG_WINDOW_HEIGHT: win.height <= cfg.data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  tcw_seq #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (items.valid),
    .item_ready (items.ready),
    .item_op    (items.op),
    .item_char  (items.char_code),
    .item_color (items.color),
    .item_index (items.cell_index),
    .win        (win),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // Cell store.
  tcw_cell_mem #(
    .DEPTH (CELLS)
  ) u_cell_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign results.valid      = out_valid;
  assign results.cursor_pos = out_res.cursor_pos;
  assign results.scrolled   = out_res.scrolled;
  assign results.cell_char  = out_res.cell_char;
  assign results.cell_color = out_res.cell_color;

endmodule
